// File: hdl/xcorr_pkg.sv
// ----------------------------------------------------------------------------
// Ten-antenna cross-correlator package
// Shared constants, types and the antenna pair table.
// ----------------------------------------------------------------------------
package xcorr_pkg;

  localparam int NUM_ANT   = 10;
  localparam int NUM_PAIRS = 45;
  localparam int NUM_OUT   = 55;
  localparam int LEN_WIDTH = 21;
  localparam logic [LEN_WIDTH-1:0] LEN_RESET = 21'd95000;

  typedef logic signed [3:0] nib_t;

  typedef struct packed {
    nib_t ar;
    nib_t ai;
    nib_t br;
    nib_t bi;
  } ant_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DUMP
  } state_t;

  function automatic logic [3:0] pair_first(input logic [5:0] k);
    logic [3:0] r;
    r = 4'd0;
    unique case (k)
      6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8: r = 4'd0;
      6'd9, 6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16: r = 4'd1;
      6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23: r = 4'd2;
      6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29: r = 4'd3;
      6'd30, 6'd31, 6'd32, 6'd33, 6'd34: r = 4'd4;
      6'd35, 6'd36, 6'd37, 6'd38: r = 4'd5;
      6'd39, 6'd40, 6'd41: r = 4'd6;
      6'd42, 6'd43: r = 4'd7;
      default: r = 4'd8;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] pair_second(input logic [5:0] k);
    logic [3:0] i;
    logic [5:0] base;
    i = pair_first(k);
    base = 6'd0;
    unique case (i)
      4'd0: base = 6'd0;
      4'd1: base = 6'd9;
      4'd2: base = 6'd17;
      4'd3: base = 6'd24;
      4'd4: base = 6'd30;
      4'd5: base = 6'd35;
      4'd6: base = 6'd39;
      4'd7: base = 6'd42;
      default: base = 6'd44;
    endcase
    return 4'(6'(k - base) + 6'(i) + 6'd1);
  endfunction

endpackage

// File: hdl/xcorr_lane.sv
// ----------------------------------------------------------------------------
// Correlator lane
// Forms one product pair per sample and keeps four saturating accumulators.
// ----------------------------------------------------------------------------
module xcorr_lane #(
  parameter int ACC_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        clear,
  input  xcorr_pkg::ant_t             x,
  input  xcorr_pkg::ant_t             y,
  output logic signed [ACC_WIDTH-1:0] acc [4]
);

  localparam logic signed [ACC_WIDTH-1:0] MAXV = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] MINV = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  logic signed [8:0] p [4];

  function automatic logic signed [ACC_WIDTH-1:0] sat_add(
    input logic signed [ACC_WIDTH-1:0] a, input logic signed [8:0] b);
    logic signed [ACC_WIDTH:0] s;
    s = {a[ACC_WIDTH-1], a} + (ACC_WIDTH+1)'(b);
    if (s[ACC_WIDTH] != s[ACC_WIDTH-1]) begin
      return s[ACC_WIDTH] ? MINV : MAXV;
    end
    return s[ACC_WIDTH-1:0];
  endfunction

  always_comb begin
    p[0] = 9'(x.ar * y.ar) + 9'(x.ai * y.ai);
    p[1] = 9'(x.ai * y.ar) - 9'(x.ar * y.ai);
    p[2] = 9'(x.br * y.br) + 9'(x.bi * y.bi);
    p[3] = 9'(x.bi * y.br) - 9'(x.br * y.bi);
  end

  always_ff @(posedge clk) begin
    for (int n = 0; n < 4; n++) begin
      if (rst || clear) begin
        acc[n] <= '0;
      end else if (en) begin
        acc[n] <= sat_add(acc[n], p[n]);
      end
    end
  end

endmodule

// File: hdl/cross_correlate_ten_antennas.sv
// ----------------------------------------------------------------------------
// Ten-antenna cross-correlator
// Fifty-five lanes accumulate all baselines and autos; a dump stage reads
// them out one result a cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// channel | direction | handshake       | payload
// in      | input     | valid / stall   | word_ant0_1 .. word_ant8_9
// out     | output    | valid / stall   | pair_index, pol_*, last_of_dump
// cfg     | input     | valid / ready   | cfg_data (integration_length)
// One sample is taken per cycle if not stalled; one that ends a period starts
// a dump of 55 results, one per cycle without stall, during which input is
// stalled. Lanes are cleared after the dump. Reset is synchronous and clears
// all accumulators at once. Output stall holds the dump where it is.
module cross_correlate_ten_antennas #(
  parameter int ACC_WIDTH   = 32,
  parameter int COUNT_WIDTH = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [31:0]         word_ant0_1,
  input  logic [31:0]         word_ant2_3,
  input  logic [31:0]         word_ant4_5,
  input  logic [31:0]         word_ant6_7,
  input  logic [31:0]         word_ant8_9,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [20:0]         cfg_data,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [5:0]          pair_index,
  output logic signed [31:0]  pol_a_real,
  output logic signed [31:0]  pol_a_imag,
  output logic signed [31:0]  pol_b_real,
  output logic signed [31:0]  pol_b_imag,
  output logic                last_of_dump
);

  localparam logic [COUNT_WIDTH:0] CAP = (COUNT_WIDTH+1)'(1) << COUNT_WIDTH;

  xcorr_pkg::state_t state, state_next;
  xcorr_pkg::ant_t   ant [xcorr_pkg::NUM_ANT];
  logic [20:0]            integration_length;
  logic [COUNT_WIDTH-1:0] sample_count;
  logic [COUNT_WIDTH:0]   len_eff;
  logic [5:0]             rd_idx;
  logic                   take, period_end, clear;
  logic signed [ACC_WIDTH-1:0] acc [xcorr_pkg::NUM_OUT][4];
  logic signed [ACC_WIDTH-1:0] sel [4];

  assign in_stall  = (state != xcorr_pkg::ST_RUN);
  assign cfg_ready = 1'b1;
  assign take      = in_valid && !in_stall;

  always_comb begin
    ant[0] = word_ant0_1[15:0];  ant[1] = word_ant0_1[31:16];
    ant[2] = word_ant2_3[15:0];  ant[3] = word_ant2_3[31:16];
    ant[4] = word_ant4_5[15:0];  ant[5] = word_ant4_5[31:16];
    ant[6] = word_ant6_7[15:0];  ant[7] = word_ant6_7[31:16];
    ant[8] = word_ant8_9[15:0];  ant[9] = word_ant8_9[31:16];
    for (int a = 0; a < xcorr_pkg::NUM_ANT; a++) begin
      ant[a] = {ant[a][3:0], ant[a][7:4], ant[a][11:8], ant[a][15:12]};
    end
  end

  always_comb begin
    if (integration_length == '0) begin
      len_eff = (COUNT_WIDTH+1)'(1);
    end else if (64'(integration_length) > 64'(CAP)) begin
      len_eff = CAP;
    end else begin
      len_eff = (COUNT_WIDTH+1)'(integration_length);
    end
    period_end = ((COUNT_WIDTH+1)'(sample_count) + 1'b1) >= len_eff;
  end

  assign clear = (state == xcorr_pkg::ST_DUMP) && !out_stall &&
                 rd_idx == 6'(xcorr_pkg::NUM_OUT - 1);

  genvar k;
  generate
    for (k = 0; k < xcorr_pkg::NUM_OUT; k++) begin : g_lane
      xcorr_pkg::ant_t xa, ya;
      if (k < xcorr_pkg::NUM_PAIRS) begin : g_x
        assign xa = ant[xcorr_pkg::pair_first(6'(k))];
        assign ya = ant[xcorr_pkg::pair_second(6'(k))];
      end else begin : g_a
        assign xa = ant[k - xcorr_pkg::NUM_PAIRS];
        assign ya = ant[k - xcorr_pkg::NUM_PAIRS];
      end
      xcorr_lane #(.ACC_WIDTH(ACC_WIDTH)) u_lane (
        .clk(clk), .rst(rst), .en(take), .clear(clear),
        .x(xa), .y(ya), .acc(acc[k])
      );
    end
  endgenerate

  always_comb begin
    state_next = state;
    unique case (state)
      xcorr_pkg::ST_RUN:  if (take && period_end) state_next = xcorr_pkg::ST_DUMP;
      xcorr_pkg::ST_DUMP: if (clear) state_next = xcorr_pkg::ST_RUN;
      default:            state_next = xcorr_pkg::ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= xcorr_pkg::ST_RUN;
      sample_count <= '0;
      rd_idx <= '0;
      integration_length <= xcorr_pkg::LEN_RESET;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) integration_length <= cfg_data;
      if (take) sample_count <= period_end ? '0 : sample_count + 1'b1;
      if (state == xcorr_pkg::ST_DUMP && !out_stall) begin
        rd_idx <= clear ? '0 : rd_idx + 1'b1;
      end
    end
  end

  function automatic logic signed [31:0] clamp32(input logic signed [ACC_WIDTH-1:0] v);
    logic signed [ACC_WIDTH+32:0] w;
    w = (ACC_WIDTH+33)'(v);
    if (w > (ACC_WIDTH+33)'(33'sh0_7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (w < -(ACC_WIDTH+33)'(33'sh0_8000_0000)) return 32'sh8000_0000;
    return w[31:0];
  endfunction

  always_comb begin
    for (int n = 0; n < 4; n++) sel[n] = acc[rd_idx][n];
  end

  always_comb begin
    out_valid    = (state == xcorr_pkg::ST_DUMP);
    pair_index   = rd_idx;
    pol_a_real   = clamp32(sel[0]);
    pol_a_imag   = (rd_idx < 6'(xcorr_pkg::NUM_PAIRS)) ? clamp32(sel[1]) : '0;
    pol_b_real   = clamp32(sel[2]);
    pol_b_imag   = (rd_idx < 6'(xcorr_pkg::NUM_PAIRS)) ? clamp32(sel[3]) : '0;
    last_of_dump = (rd_idx == 6'(xcorr_pkg::NUM_OUT - 1));
  end

  a_no_take_in_dump: assert property (@(posedge clk) disable iff (rst)
    state == xcorr_pkg::ST_DUMP |-> !take) else $error("input taken during dump");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    rd_idx < 6'(xcorr_pkg::NUM_OUT)) else $error("read index out of range");
  a_idx_zero_run: assert property (@(posedge clk) disable iff (rst)
    state == xcorr_pkg::ST_RUN |-> rd_idx == '0) else $error("index not reset");
  a_dump_start: assert property (@(posedge clk) disable iff (rst)
    (take && period_end) |=> state == xcorr_pkg::ST_DUMP) else $error("no dump");

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// Ten-antenna cross-correlator testbench
// Drives spectral samples with random bursts and gaps, stalls the output on
// its own pattern, and compares every dump result with a local predictor of
// the saturating baseline and auto accumulators across several period lengths.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam longint ACC_HI = 64'sd2147483647;
  localparam longint ACC_LO = -64'sd2147483648;
  localparam int CAP = 1 << 20;

  typedef struct packed {
    logic [5:0] idx;
    logic signed [31:0] ar;
    logic signed [31:0] ai;
    logic signed [31:0] br;
    logic signed [31:0] bi;
    logic last;
  } corr_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [31:0] w0 = '0, w1 = '0, w2 = '0, w3 = '0, w4 = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [20:0] cfg_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [5:0] pair_index;
  logic signed [31:0] pol_a_real, pol_a_imag, pol_b_real, pol_b_imag;
  logic last_of_dump;

  longint cross_sum [xcorr_pkg::NUM_PAIRS*4];
  longint auto_sum [xcorr_pkg::NUM_ANT*2];
  int unsigned samples_in_period;
  int unsigned period_len;
  corr_res_t dump_queue [$];
  int errors = 0;
  int idle_cycles = 0;
  int stall_mode = 0;
  bit sat_bias = 0;

  always #5 clk = ~clk;

  cross_correlate_ten_antennas u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .word_ant0_1(w0), .word_ant2_3(w1), .word_ant4_5(w2),
    .word_ant6_7(w3), .word_ant8_9(w4),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .pair_index(pair_index), .pol_a_real(pol_a_real), .pol_a_imag(pol_a_imag),
    .pol_b_real(pol_b_real), .pol_b_imag(pol_b_imag),
    .last_of_dump(last_of_dump)
  );

  function automatic longint sat_acc(longint acc, longint p);
    longint s;
    s = acc + p;
    if (s > ACC_HI) return ACC_HI;
    if (s < ACC_LO) return ACC_LO;
    return s;
  endfunction

  function automatic longint nibble(logic [31:0] w, int pos);
    logic signed [3:0] n;
    n = w[pos*4 +: 4];
    return longint'(n);
  endfunction

  task automatic correlate_sample(input logic [31:0] words [5]);
    longint ar [xcorr_pkg::NUM_ANT], ai [xcorr_pkg::NUM_ANT];
    longint br [xcorr_pkg::NUM_ANT], bi [xcorr_pkg::NUM_ANT];
    int k;
    int unsigned eff;
    corr_res_t r;
    for (int a = 0; a < xcorr_pkg::NUM_ANT; a++) begin
      ar[a] = nibble(words[a/2], (a%2)*4);
      ai[a] = nibble(words[a/2], (a%2)*4 + 1);
      br[a] = nibble(words[a/2], (a%2)*4 + 2);
      bi[a] = nibble(words[a/2], (a%2)*4 + 3);
    end
    k = 0;
    for (int i = 0; i < xcorr_pkg::NUM_ANT - 1; i++) begin
      for (int j = i + 1; j < xcorr_pkg::NUM_ANT; j++) begin
        cross_sum[k*4]   = sat_acc(cross_sum[k*4],   ar[i]*ar[j] + ai[i]*ai[j]);
        cross_sum[k*4+1] = sat_acc(cross_sum[k*4+1], ai[i]*ar[j] - ar[i]*ai[j]);
        cross_sum[k*4+2] = sat_acc(cross_sum[k*4+2], br[i]*br[j] + bi[i]*bi[j]);
        cross_sum[k*4+3] = sat_acc(cross_sum[k*4+3], bi[i]*br[j] - br[i]*bi[j]);
        k++;
      end
    end
    for (int a = 0; a < xcorr_pkg::NUM_ANT; a++) begin
      auto_sum[a*2]   = sat_acc(auto_sum[a*2],   ar[a]*ar[a] + ai[a]*ai[a]);
      auto_sum[a*2+1] = sat_acc(auto_sum[a*2+1], br[a]*br[a] + bi[a]*bi[a]);
    end
    eff = (period_len == 0) ? 1 : (period_len > CAP ? CAP : period_len);
    if (samples_in_period + 1 < eff) begin
      samples_in_period++;
      return;
    end
    for (int p = 0; p < xcorr_pkg::NUM_PAIRS; p++) begin
      r.idx = 6'(p);
      r.ar = 32'(cross_sum[p*4]);
      r.ai = 32'(cross_sum[p*4+1]);
      r.br = 32'(cross_sum[p*4+2]);
      r.bi = 32'(cross_sum[p*4+3]);
      r.last = 1'b0;
      dump_queue.push_back(r);
    end
    for (int a = 0; a < xcorr_pkg::NUM_ANT; a++) begin
      r.idx = 6'(xcorr_pkg::NUM_PAIRS + a);
      r.ar = 32'(auto_sum[a*2]);
      r.ai = '0;
      r.br = 32'(auto_sum[a*2+1]);
      r.bi = '0;
      r.last = (a == xcorr_pkg::NUM_ANT - 1);
      dump_queue.push_back(r);
    end
    foreach (cross_sum[i]) cross_sum[i] = 0;
    foreach (auto_sum[i]) auto_sum[i] = 0;
    samples_in_period = 0;
  endtask

  task automatic send_sample(input logic [31:0] words [5]);
    in_valid <= 1'b1;
    w0 <= words[0]; w1 <= words[1]; w2 <= words[2]; w3 <= words[3]; w4 <= words[4];
    do @(posedge clk); while (in_stall);
    correlate_sample(words);
    @(negedge clk);
  endtask

  task automatic send_random(input int count, input bit bursty);
    logic [31:0] words [5];
    int burst;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      for (int i = 0; i < 5; i++) begin
        words[i] = $urandom;
        // Extreme nibbles drive the accumulators toward saturation.
        if (sat_bias) words[i] = ($urandom_range(0, 1)) ? 32'h88888888 : 32'h77777777;
      end
      send_sample(words);
      if (bursty) begin
        if (burst == 0) begin
          burst = $urandom_range(1, 12);
          if ($urandom_range(0, 2) != 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
          end
        end
        burst--;
      end
    end
    in_valid <= 1'b0;
  endtask

  task automatic drain_results();
    while (dump_queue.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_length(input int unsigned len);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= 21'(len);
    do @(posedge clk); while (!cfg_ready);
    period_len = len & 21'h1FFFFF;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed_extremes();
    logic [31:0] words [5];
    logic [31:0] pats [6] = '{32'h0, 32'hFFFFFFFF, 32'h88888888, 32'h77777777,
                              32'h12345678, 32'h8F7E01A5};
    write_length(1);
    foreach (pats[p]) begin
      for (int i = 0; i < 5; i++) words[i] = pats[(p + i) % 6];
      send_sample(words);
    end
    in_valid <= 1'b0;
    write_length(0);
    for (int i = 0; i < 5; i++) words[i] = 32'h8787_7878;
    send_sample(words);
    in_valid <= 1'b0;
    write_length(5);
    send_random(12, 0);
  endtask

  task automatic test_length_lowered();
    logic [31:0] words [5];
    write_length(20);
    send_random(8, 0);
    write_length(3);
    for (int i = 0; i < 5; i++) words[i] = $urandom;
    send_sample(words);
    in_valid <= 1'b0;
    drain_results();
  endtask

  task automatic test_random_periods();
    int unsigned lens [5] = '{1, 2, 7, 30, 64};
    foreach (lens[i]) begin
      stall_mode = i % 3;
      write_length(lens[i]);
      send_random(lens[i] * ((i < 2) ? 20 : 2), 1);
    end
    drain_results();
  endtask

  task automatic test_saturation();
    stall_mode = 0;
    sat_bias = 1;
    write_length(21'h1FFFFF);
    send_random(40, 1);
    sat_bias = 0;
    write_length(CAP);
    send_random(10, 1);
    write_length(4);
    send_random(4, 0);
    drain_results();
  endtask

  always @(negedge clk) begin
    case (stall_mode)
      0: out_stall <= ($urandom_range(0, 3) == 0);
      1: out_stall <= 1'b0;
      default: out_stall <= ($urandom_range(0, 9) < 6);
    endcase
  end

  always @(posedge clk) begin
    corr_res_t e;
    if (!rst && out_valid && !out_stall) begin
      if (dump_queue.size() == 0) begin
        $error("unexpected result pair_index=%0d", pair_index);
        errors++;
      end else begin
        e = dump_queue.pop_front();
        if (pair_index !== e.idx) begin
          $error("pair_index exp %0d got %0d", e.idx, pair_index); errors++;
        end
        if (pol_a_real !== e.ar) begin
          $error("pol_a_real exp %0d got %0d", e.ar, pol_a_real); errors++;
        end
        if (pol_a_imag !== e.ai) begin
          $error("pol_a_imag exp %0d got %0d", e.ai, pol_a_imag); errors++;
        end
        if (pol_b_real !== e.br) begin
          $error("pol_b_real exp %0d got %0d", e.br, pol_b_real); errors++;
        end
        if (pol_b_imag !== e.bi) begin
          $error("pol_b_imag exp %0d got %0d", e.bi, pol_b_imag); errors++;
        end
        if (last_of_dump !== e.last) begin
          $error("last_of_dump exp %0d got %0d", e.last, last_of_dump); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    foreach (cross_sum[i]) cross_sum[i] = 0;
    foreach (auto_sum[i]) auto_sum[i] = 0;
    samples_in_period = 0;
    period_len = xcorr_pkg::LEN_RESET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_extremes();
    test_length_lowered();
    test_random_periods();
    test_saturation();
    drain_results();
    repeat (60) @(negedge clk);
    if (errors == 0 && dump_queue.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end
endmodule
